// ----- design/pc_relative_target_decoder_defines.svh -----
// ----------------------------------------------------------------------------
// pc_relative_target_decoder_defines.svh
// Assertion macros shared by the PC-relative target decoder.
// ----------------------------------------------------------------------------
`ifndef PC_RELATIVE_TARGET_DECODER_DEFINES_SVH
`define PC_RELATIVE_TARGET_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PCRTD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pcrtd same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PCRTD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pcrtd next-cycle check failed");

`endif

// ----- design/pcrtd_pkg.sv -----
// ----------------------------------------------------------------------------
// pcrtd_pkg
// Types and constants of the PC-relative target decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcrtd_pkg;

	// form selector codes
	localparam logic [2:0] ACT_BRANCH = 3'd0;
	localparam logic [2:0] ACT_CMPBR  = 3'd1;
	localparam logic [2:0] ACT_TSTBR  = 3'd2;
	localparam logic [2:0] ACT_ADR    = 3'd3;
	localparam logic [2:0] ACT_ADRP   = 3'd4;

	// bits 30:26 of an unconditional B or BL
	localparam logic [4:0] B_UNCOND_OP = 5'b00101;

	localparam int unsigned ADDR_W = 64;
	localparam int unsigned HALF_W = ADDR_W / 2;

	// decoded side fields that ride along with the target
	typedef struct packed {
		logic [4:0] reg_number;
		logic       is_conditional;
		logic [3:0] cond_code;
		logic       wide_register;
		logic [5:0] test_bit;
	} side_t;

	// stage load strobes from the handshake control
	typedef struct packed {
		logic load_s1;
		logic load_s2;
		logic load_s3;
	} pipe_ctrl_t;

endpackage

// ----- design/pc_relative_target_decoder.sv -----
// ----------------------------------------------------------------------------
// pc_relative_target_decoder
// Decode A64 PC-relative branch and address forms into a 64-bit target.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries action, instruction_word and
//   program_counter. Output channel (out_valid/out_ready) carries the target
//   address plus register, condition, sf and tested-bit fields, one result
//   per input transfer, in order.
//   Path: each item passes the decode, low-half add and high-half add stage
//   registers in turn. The last stage register drives the outputs.
//   Throughput: one item per cycle while out_ready stays high.
//   Stall: when out_ready is low the output holds; earlier stages keep
//   filling, so up to three items sit in flight before in_ready drops.
//   Reset: arst_n clears every stage valid bit; payload registers are not
//   reset. The block accepts a transfer as soon as reset is released.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pc_relative_target_decoder_defines.svh"

module pc_relative_target_decoder import pcrtd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        action,
	input  logic [31:0]       instruction_word,
	input  logic [ADDR_W-1:0] program_counter,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ADDR_W-1:0] target_address,
	output logic [4:0]        reg_number,
	output logic              is_conditional,
	output logic [3:0]        cond_code,
	output logic              wide_register,
	output logic [5:0]        test_bit
);

	// stage valid bits
	logic valid_s1;
	logic valid_s2;
	logic valid_s3;

	// per-stage room: a stage can load when empty or when it drains
	logic room_s1;
	logic room_s2;
	logic room_s3;

	pipe_ctrl_t        ctrl;
	logic [ADDR_W-1:0] base_s1;
	logic [ADDR_W-1:0] offset_s1;
	side_t             side_s1;
	logic [ADDR_W-1:0] sum_s3;
	side_t             side_s3;

	// backward ready chain
	assign room_s3 = !valid_s3 || out_ready;
	assign room_s2 = !valid_s2 || room_s3;
	assign room_s1 = !valid_s1 || room_s2;

	assign ctrl.load_s1 = in_valid && room_s1;
	assign ctrl.load_s2 = valid_s1 && room_s2;
	assign ctrl.load_s3 = valid_s2 && room_s3;

	assign in_ready = room_s1;

	// advance valid bits; hold a stage whose successor is full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= ctrl.load_s1 || (valid_s1 && !room_s2);
			valid_s2 <= ctrl.load_s2 || (valid_s2 && !room_s3);
			valid_s3 <= ctrl.load_s3 || (valid_s3 && !out_ready);
		end
	end

	// stage 1: form decode, base and offset selection
	pcrtd_decode u_decode (
		.clk              (clk),
		.load             (ctrl.load_s1),
		.action           (action),
		.instruction_word (instruction_word),
		.program_counter  (program_counter),
		.base_s1          (base_s1),
		.offset_s1        (offset_s1),
		.side_s1          (side_s1)
	);

	// stages 2 and 3: split add into the output register
	pcrtd_add u_add (
		.clk       (clk),
		.ctrl      (ctrl),
		.base_s1   (base_s1),
		.offset_s1 (offset_s1),
		.side_s1   (side_s1),
		.sum_s3    (sum_s3),
		.side_s3   (side_s3)
	);

	assign out_valid      = valid_s3;
	assign target_address = sum_s3;
	assign reg_number     = side_s3.reg_number;
	assign is_conditional = side_s3.is_conditional;
	assign cond_code      = side_s3.cond_code;
	assign wide_register  = side_s3.wide_register;
	assign test_bit       = side_s3.test_bit;

	// an empty first stage never refuses a transfer
	`PCRTD_ASSERT_NOW(a_empty_s1_ready, !valid_s1, in_ready)
	// backpressure reaches the input only with every stage full
	`PCRTD_ASSERT_NOW(a_full_when_blocked, !in_ready, valid_s1 && valid_s2 && valid_s3)
	// an item moving out of stage 2 shows up at the output
	`PCRTD_ASSERT_NEXT(a_s2_to_out, valid_s2 && room_s3, out_valid)
	// a stage 2 item blocked by a full output stays put
	`PCRTD_ASSERT_NEXT(a_s2_hold, valid_s2 && !room_s3, valid_s2)

endmodule

// ----- design/pcrtd_decode.sv -----
// ----------------------------------------------------------------------------
// pcrtd_decode
// Stage 1: select the form, build base and scaled offset, extract fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcrtd_decode import pcrtd_pkg::*; (
	input  logic                clk,
	input  logic                load,
	input  logic [2:0]          action,
	input  logic [31:0]         instruction_word,
	input  logic [ADDR_W-1:0]   program_counter,
	output logic [ADDR_W-1:0]   base_s1,
	output logic [ADDR_W-1:0]   offset_s1,
	output side_t               side_s1
);

	logic [ADDR_W-1:0] base_d;
	logic [ADDR_W-1:0] offset_d;
	side_t             side_d;
	logic [20:0]       adr_imm;

	assign adr_imm = {instruction_word[23:5], instruction_word[30:29]};

	always_comb begin
		base_d   = '0;
		offset_d = '0;
		side_d   = '0;
		unique case (action)
			ACT_BRANCH: begin
				base_d = program_counter;
				if (instruction_word[30:26] == B_UNCOND_OP) begin
					offset_d = {{36{instruction_word[25]}}, instruction_word[25:0], 2'b00};
				end else begin
					offset_d = {{43{instruction_word[23]}}, instruction_word[23:5], 2'b00};
					side_d.is_conditional = 1'b1;
					side_d.cond_code      = instruction_word[3:0];
				end
			end
			ACT_CMPBR: begin
				base_d   = program_counter;
				offset_d = {{43{instruction_word[23]}}, instruction_word[23:5], 2'b00};
				side_d.reg_number    = instruction_word[4:0];
				side_d.wide_register = instruction_word[31];
			end
			ACT_TSTBR: begin
				base_d   = program_counter;
				offset_d = {{48{instruction_word[18]}}, instruction_word[18:5], 2'b00};
				side_d.reg_number = instruction_word[4:0];
				side_d.test_bit   = {instruction_word[31], instruction_word[23:19]};
			end
			ACT_ADR: begin
				base_d   = program_counter;
				offset_d = {{43{adr_imm[20]}}, adr_imm};
				side_d.reg_number = instruction_word[4:0];
			end
			ACT_ADRP: begin
				// page base: drop the low 12 bits of the PC
				base_d   = {program_counter[ADDR_W-1:12], 12'h000};
				offset_d = {{31{adr_imm[20]}}, adr_imm, 12'h000};
				side_d.reg_number = instruction_word[4:0];
			end
			default: begin
				// unused selectors give an all-zero result
				base_d   = '0;
				offset_d = '0;
				side_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			base_s1   <= base_d;
			offset_s1 <= offset_d;
			side_s1   <= side_d;
		end
	end

endmodule

// ----- design/pcrtd_add.sv -----
// ----------------------------------------------------------------------------
// pcrtd_add
// Stages 2 and 3: split 64-bit add, low half then high half with carry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcrtd_add import pcrtd_pkg::*; (
	input  logic              clk,
	input  pipe_ctrl_t        ctrl,
	input  logic [ADDR_W-1:0] base_s1,
	input  logic [ADDR_W-1:0] offset_s1,
	input  side_t             side_s1,
	output logic [ADDR_W-1:0] sum_s3,
	output side_t             side_s3
);

	logic [HALF_W-1:0] lo_sum_s2;
	logic              carry_s2;
	logic [HALF_W-1:0] base_hi_s2;
	logic [HALF_W-1:0] offset_hi_s2;
	side_t             side_s2;
	logic [HALF_W:0]   lo_wide;

	assign lo_wide = {1'b0, base_s1[HALF_W-1:0]} + {1'b0, offset_s1[HALF_W-1:0]};

	always_ff @(posedge clk) begin
		if (ctrl.load_s2) begin
			lo_sum_s2    <= lo_wide[HALF_W-1:0];
			carry_s2     <= lo_wide[HALF_W];
			base_hi_s2   <= base_s1[ADDR_W-1:HALF_W];
			offset_hi_s2 <= offset_s1[ADDR_W-1:HALF_W];
			side_s2      <= side_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_s3) begin
			// carry out of the top half is dropped: the sum wraps
			sum_s3  <= {base_hi_s2 + offset_hi_s2 + {{(HALF_W-1){1'b0}}, carry_s2}, lo_sum_s2};
			side_s3 <= side_s2;
		end
	end

endmodule
